// ----- rtl/rrlf_pkg.sv -----
`timescale 1ns / 1ps

package rrlf_pkg;

    // Size of the job list and derived widths.
    localparam int NUM_ENTRIES = 32;
    localparam int ENT_IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ENT_CNT_W   = $clog2(NUM_ENTRIES + 1);

    // Channel and level formats.
    localparam int NUM_CHANNELS = 32;
    localparam int CH_W         = 5;
    localparam int LVL_W        = 12;

    // Configuration registers.
    localparam int STEP_W     = 8;
    localparam int LIMIT_W    = 16;
    localparam int SWEEP_W    = LIMIT_W + 1;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0]     STEP_RESET      = 8'd5;
    localparam logic [LIMIT_W-1:0]    LIMIT_RESET     = 16'd1000;
    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWEEP_LIMIT = 1'b1;

    // Stream payload width: channel and level packed, padded to whole bytes.
    localparam int TDATA_W = 24;
    localparam int TPAD_W  = TDATA_W - CH_W - LVL_W;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_ENROL = 1'b0,
        OP_SWEEP = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CH_W-1:0]  channel;
        logic [LVL_W-1:0] target;
    } cmd_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [LIMIT_W-1:0] sweep_limit;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [LVL_W-1:0] level;
        logic             last;
        logic             finished;
    } res_t;

endpackage

// ----- rtl/rrlf_front.sv -----
`timescale 1ns / 1ps

module rrlf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rrlf_pkg::TDATA_W-1:0]  s_axis_tdata,   // channel, target, zero pad
    input  logic                          s_axis_tuser,   // op
    output logic                          cmd_valid,
    output rrlf_pkg::cmd_t                cmd,
    input  logic                          cmd_pop
);
    import rrlf_pkg::*;

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              in_cmd;
    logic              push;
    logic              pop;

    // Decode the request into a command for the back end.
    assign in_cmd.op      = op_t'(s_axis_tuser);
    assign in_cmd.channel = s_axis_tdata[CH_W-1:0];
    assign in_cmd.target  = s_axis_tdata[CH_W +: LVL_W];

    assign s_axis_tready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid     = (cnt_reg != '0);
    assign cmd           = queue_reg[rd_ptr_reg];

    assign push = s_axis_tvalid && s_axis_tready;
    assign pop  = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ----- rtl/rrlf_back.sv -----
`timescale 1ns / 1ps

module rrlf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rrlf_pkg::cfg_t cfg,
    input  logic           cmd_valid,
    input  rrlf_pkg::cmd_t cmd,
    output logic           cmd_pop,
    output logic           res_valid,
    output rrlf_pkg::res_t res,
    input  logic           res_ready
);
    import rrlf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ENROL = 4'b0010,
        ST_SWEEP = 4'b0100,
        ST_CLOSE = 4'b1000
    } state_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [LVL_W-1:0] target;
        logic [LVL_W-1:0] level;
    } entry_t;

    // Job list and channel level memories.
    entry_t           ent_mem [NUM_ENTRIES];
    entry_t           ent_rd_reg;
    logic [LVL_W-1:0] chl_mem [NUM_CHANNELS];
    logic [LVL_W-1:0] chl_rd_reg;

    logic                 ent_we, ent_re;
    logic [ENT_IDX_W-1:0] ent_waddr, ent_raddr;
    entry_t               ent_wdata;
    logic                 chl_we, chl_re;
    logic [CH_W-1:0]      chl_waddr, chl_raddr;
    logic [LVL_W-1:0]     chl_wdata;

    state_t                 state_reg, state_next;
    logic [ENT_CNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [ENT_CNT_W-1:0]   done_count_reg, done_count_next;
    logic [SWEEP_W-1:0]     sweep_count_reg, sweep_count_next;
    logic [NUM_ENTRIES-1:0] done_reg, done_next;
    logic [NUM_CHANNELS-1:0] chv_reg, chv_next;
    logic                   chv_rd_reg, chv_rd_next;
    logic [ENT_CNT_W-1:0]   idx_reg, idx_next;
    logic                   s1_vld_reg, s1_vld_next;
    logic [ENT_IDX_W-1:0]   s1_idx_reg, s1_idx_next;
    logic [CH_W-1:0]        enr_ch_reg, enr_ch_next;
    logic [LVL_W-1:0]       enr_tgt_reg, enr_tgt_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic [CH_W-1:0]        pend_ch_reg, pend_ch_next;
    logic [LVL_W-1:0]       pend_lvl_reg, pend_lvl_next;
    logic                   out_vld_reg, out_vld_next;
    res_t                   out_reg, out_next;

    logic                 out_free;
    logic                 exe_fire;
    logic                 issue_ok;
    logic                 list_end;
    logic [ENT_IDX_W-1:0] idx_lo;
    logic [LVL_W-1:0]     cur_lvl, cur_tgt, step, gap, new_lvl;
    logic                 step_up, hit;
    logic [SWEEP_W-1:0]   sweep_inc;
    logic                 job_fin;
    logic                 close_go;

    // Step one entry toward its target.
    always_comb
    begin
        cur_lvl = ent_rd_reg.level;
        cur_tgt = ent_rd_reg.target;
        step    = LVL_W'(cfg.step_size);
        step_up = (cur_tgt > cur_lvl);
        gap     = step_up ? (cur_tgt - cur_lvl) : (cur_lvl - cur_tgt);
        priority if (cur_tgt == cur_lvl)
        begin
            new_lvl = cur_lvl;
            hit     = 1'b1;
        end
        else if (gap < step)
        begin
            new_lvl = cur_tgt;
            hit     = 1'b1;
        end
        else if (step_up)
        begin
            new_lvl = cur_lvl + step;
            hit     = 1'b0;
        end
        else
        begin
            new_lvl = cur_lvl - step;
            hit     = 1'b0;
        end
    end

    assign out_free  = !out_vld_reg || res_ready;
    assign exe_fire  = s1_vld_reg && (!pend_vld_reg || out_free);
    assign list_end  = !(idx_reg < entry_count_reg);
    assign issue_ok  = (state_reg == ST_SWEEP) && !list_end && (!s1_vld_reg || exe_fire);
    assign idx_lo    = idx_reg[ENT_IDX_W-1:0];
    assign sweep_inc = sweep_count_reg + SWEEP_W'(1);
    assign job_fin   = (done_count_reg >= entry_count_reg)
                    || (sweep_inc > SWEEP_W'(cfg.sweep_limit));
    assign close_go  = !pend_vld_reg || out_free;
    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;

    assign res_valid = out_vld_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        done_count_next  = done_count_reg;
        sweep_count_next = sweep_count_reg;
        done_next        = done_reg;
        chv_next         = chv_reg;
        chv_rd_next      = chv_rd_reg;
        idx_next         = idx_reg;
        s1_vld_next      = s1_vld_reg;
        s1_idx_next      = s1_idx_reg;
        enr_ch_next      = enr_ch_reg;
        enr_tgt_next     = enr_tgt_reg;
        pend_vld_next    = pend_vld_reg;
        pend_ch_next     = pend_ch_reg;
        pend_lvl_next    = pend_lvl_reg;
        out_vld_next     = out_vld_reg && !res_ready;
        out_next         = out_reg;

        ent_we    = 1'b0;
        ent_waddr = s1_idx_reg;
        ent_wdata = '{channel: ent_rd_reg.channel, target: ent_rd_reg.target, level: new_lvl};
        ent_re    = 1'b0;
        ent_raddr = idx_lo;
        chl_we    = 1'b0;
        chl_waddr = ent_rd_reg.channel;
        chl_wdata = new_lvl;
        chl_re    = 1'b0;
        chl_raddr = cmd.channel;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == OP_SWEEP)
                    begin
                        idx_next   = '0;
                        state_next = ST_SWEEP;
                    end
                    else if (entry_count_reg < ENT_CNT_W'(NUM_ENTRIES))
                    begin
                        // Fetch the channel's present level for the new entry.
                        chl_re       = 1'b1;
                        chv_rd_next  = chv_reg[cmd.channel];
                        enr_ch_next  = cmd.channel;
                        enr_tgt_next = cmd.target;
                        state_next   = ST_ENROL;
                    end
                end
            end

            ST_ENROL:
            begin
                ent_we    = 1'b1;
                ent_waddr = entry_count_reg[ENT_IDX_W-1:0];
                ent_wdata = '{channel: enr_ch_reg, target: enr_tgt_reg,
                              level: chv_rd_reg ? chl_rd_reg : '0};
                done_next[entry_count_reg[ENT_IDX_W-1:0]] = 1'b0;
                entry_count_next = entry_count_reg + ENT_CNT_W'(1);
                state_next       = ST_IDLE;
            end

            ST_SWEEP:
            begin
                if (exe_fire)
                begin
                    ent_we = 1'b1;
                    chl_we = 1'b1;
                    chv_next[ent_rd_reg.channel] = 1'b1;
                    if (hit)
                    begin
                        done_next[s1_idx_reg] = 1'b1;
                        done_count_next       = done_count_reg + ENT_CNT_W'(1);
                    end
                    // The held update is now known not to be the sweep's last.
                    if (pend_vld_reg)
                    begin
                        out_vld_next = 1'b1;
                        out_next     = '{channel: pend_ch_reg, level: pend_lvl_reg,
                                         last: 1'b0, finished: 1'b0};
                    end
                    pend_vld_next = 1'b1;
                    pend_ch_next  = ent_rd_reg.channel;
                    pend_lvl_next = new_lvl;
                end

                if (issue_ok)
                begin
                    ent_re      = !done_reg[idx_lo];
                    s1_vld_next = !done_reg[idx_lo];
                    s1_idx_next = idx_lo;
                    idx_next    = idx_reg + ENT_CNT_W'(1);
                end
                else if (exe_fire)
                begin
                    s1_vld_next = 1'b0;
                end

                if (list_end && (!s1_vld_reg || exe_fire))
                begin
                    state_next = ST_CLOSE;
                end
            end

            ST_CLOSE:
            begin
                if (close_go)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_next      = '{channel: pend_ch_reg, level: pend_lvl_reg,
                                          last: 1'b1, finished: job_fin};
                        pend_vld_next = 1'b0;
                    end
                    if (job_fin)
                    begin
                        done_next        = '0;
                        entry_count_next = '0;
                        done_count_next  = '0;
                        sweep_count_next = '0;
                    end
                    else
                    begin
                        sweep_count_next = sweep_inc;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rd_reg <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (chl_we)
        begin
            chl_mem[chl_waddr] <= chl_wdata;
        end
        if (chl_re)
        begin
            chl_rd_reg <= chl_mem[chl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= s1_idx_next;
        enr_ch_reg   <= enr_ch_next;
        enr_tgt_reg  <= enr_tgt_next;
        pend_ch_reg  <= pend_ch_next;
        pend_lvl_reg <= pend_lvl_next;
        out_reg      <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            done_count_reg  <= '0;
            sweep_count_reg <= '0;
            done_reg        <= '0;
            chv_reg         <= '0;
            chv_rd_reg      <= 1'b0;
            idx_reg         <= '0;
            s1_vld_reg      <= 1'b0;
            pend_vld_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            done_count_reg  <= done_count_next;
            sweep_count_reg <= sweep_count_next;
            done_reg        <= done_next;
            chv_reg         <= chv_next;
            chv_rd_reg      <= chv_rd_next;
            idx_reg         <= idx_next;
            s1_vld_reg      <= s1_vld_next;
            pend_vld_reg    <= pend_vld_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= ENT_CNT_W'(NUM_ENTRIES))
        else $error("job list count beyond its capacity");

    a_done_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_count_reg <= entry_count_reg)
        else $error("more finished entries than enrolled entries");

    a_stage_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg |-> (state_reg == ST_SWEEP))
        else $error("entry read in flight outside a sweep");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg)
        else $error("held update left behind after a sweep");

    a_finish_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_reg.finished) |-> out_reg.last)
        else $error("job end flagged on an update that does not close the sweep");

    a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_CLOSE) && !pend_vld_reg) |=> (state_reg == ST_IDLE))
        else $error("sweep close did not return to idle");

endmodule

// ----- rtl/round_robin_led_fade_engine_unit.sv -----
`timescale 1ns / 1ps

// Fade engine for 32 PWM channels with 12-bit levels.
// Requests arrive on the s_axis channel: tuser selects enrol (0) or sweep (1),
// and tdata carries the channel and target level used by an enrol. An enrol
// appends an entry to the job list unless the list is full, and copies the channel's present level;
// it produces no update. A sweep steps every unfinished entry toward its
// target by step_size and sends one update per visited entry on m_axis: tdata
// holds channel and new level, tlast marks the sweep's final update and tuser
// marks that the job ended with it (all entries done or sweep limit passed).
// The two configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata while the engine is idle.
// A two-deep request queue sits in front of the sequencer. An enrol takes
// the sequencer through its ENROL state and back to idle. A sweep reads one
// list entry per cycle from the job list memory while it writes back the
// entry before it, when m_axis keeps up, and then closes in the CLOSE state.
// Each update is held back one entry so that tlast can be set on the true
// final one; when m_axis stalls, the sequencer pauses and nothing is lost.
// Reset clears the job list, all channel levels to zero, and loads the
// registers with step 5 and sweep limit 1000; no clearing pass is needed.
module round_robin_led_fade_engine_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [rrlf_pkg::TDATA_W-1:0]     s_axis_tdata,   // channel[4:0], target[16:5], zero pad
    input  logic                             s_axis_tuser,   // op
    // Update stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [rrlf_pkg::TDATA_W-1:0]     m_axis_tdata,   // out_channel[4:0], out_level[16:5], zero pad
    output logic                             m_axis_tlast,   // last_of_sweep
    output logic                             m_axis_tuser,   // job_finished
    // Configuration writes.
    input  logic                             cfg_wr_en,
    input  logic [rrlf_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rrlf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rrlf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    // Configuration register file. Only the low bits of the write data that
    // fit a register are kept.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STEP_SIZE:   cfg_next.step_size   = cfg_wdata[STEP_W-1:0];
                REG_SWEEP_LIMIT: cfg_next.sweep_limit = cfg_wdata[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size   <= STEP_RESET;
            cfg_reg.sweep_limit <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: takes requests, decodes them and queues them.
    rrlf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    // Back end: job list, channel levels and the sweep sequencer.
    rrlf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (m_axis_tvalid),
        .res       (res),
        .res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{TPAD_W{1'b0}}, res.level, res.channel};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.finished;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rrlf_pkg::*;

    // Cycles the engine is left alone before a register write or the end of
    // the run. An enrol may still sit in the two-deep queue or in the
    // sequencer when the last update has already left.
    localparam int SETTLE_CYCLES = 16;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata = '0;   // channel[4:0], target[16:5], zero pad
    logic                  s_axis_tuser = 1'b0; // op

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;        // out_channel[4:0], out_level[16:5], zero pad
    logic                  m_axis_tlast;        // last_of_sweep
    logic                  m_axis_tuser;        // job_finished

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    round_robin_led_fade_engine_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Requests waiting for the driver, and the channel updates the fade
    // predictor says must come out, oldest first.
    cmd_t pending_reqs[$];
    res_t expected_updates[$];

    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // Set by the monitor at the edge where the driven request is taken,
    // cleared by the driver when it moves on to the next one.
    bit   req_taken = 1'b0;

    // Predictor state: channel levels, the job list and its counters, and a
    // copy of the two registers.
    logic [LVL_W-1:0]   chan_level [NUM_CHANNELS];
    logic [CH_W-1:0]    job_chan   [NUM_ENTRIES];
    logic [LVL_W-1:0]   job_target [NUM_ENTRIES];
    logic [LVL_W-1:0]   job_level  [NUM_ENTRIES];
    bit                 job_done   [NUM_ENTRIES];
    int                 job_len = 0;
    int                 job_done_cnt = 0;
    int                 sweeps_run = 0;
    logic [STEP_W-1:0]  step_cfg = STEP_RESET;
    logic [LIMIT_W-1:0] limit_cfg = LIMIT_RESET;

    initial
    begin
        forever #2 clk = ~clk;
    end

    // The run is bounded by a fixed time far beyond the slowest legal run:
    // every sweep of a full list, each update waiting out long stalls.
    initial
    begin
        #2400000;
        $display("tb: failure");
        $finish;
    end

    // Applies one accepted request to the predictor. An enrol appends an
    // entry that starts from the channel's present level, unless the list
    // is full. A sweep steps every unfinished entry toward its target, or
    // snaps it there when the gap is below the step, and queues one update
    // per visited entry; the last one carries the end-of-sweep and job-ended
    // flags.
    task automatic fade_predict(input cmd_t req);
        res_t        sweep_out[$];
        res_t        upd;
        int unsigned lvl;
        int unsigned tgt;
        int unsigned gap;
        bit          finished;
        if (req.op == OP_ENROL)
        begin
            if (job_len < NUM_ENTRIES)
            begin
                job_chan[job_len]   = req.channel;
                job_target[job_len] = req.target;
                job_level[job_len]  = chan_level[req.channel];
                job_done[job_len]   = 1'b0;
                job_len++;
            end
            return;
        end
        for (int i = 0; i < job_len; i++)
        begin
            if (!job_done[i])
            begin
                lvl = 32'(job_level[i]);
                tgt = 32'(job_target[i]);
                if (tgt == lvl)
                begin
                    // Already on target: marked done, still written out.
                    job_done[i] = 1'b1;
                    job_done_cnt++;
                end
                else
                begin
                    gap = (tgt > lvl) ? tgt - lvl : lvl - tgt;
                    if (gap < 32'(step_cfg))
                    begin
                        lvl = tgt;
                        job_done[i] = 1'b1;
                        job_done_cnt++;
                    end
                    else if (tgt > lvl)
                        lvl = lvl + 32'(step_cfg);
                    else
                        lvl = lvl - 32'(step_cfg);
                end
                job_level[i] = lvl[LVL_W-1:0];
                chan_level[job_chan[i]] = lvl[LVL_W-1:0];
                upd.channel  = job_chan[i];
                upd.level    = lvl[LVL_W-1:0];
                upd.last     = 1'b0;
                upd.finished = 1'b0;
                sweep_out.push_back(upd);
            end
        end
        sweeps_run++;
        finished = (job_done_cnt >= job_len) || (sweeps_run > int'(limit_cfg));
        if (sweep_out.size() > 0)
        begin
            sweep_out[sweep_out.size() - 1].last     = 1'b1;
            sweep_out[sweep_out.size() - 1].finished = finished;
        end
        foreach (sweep_out[k])
            expected_updates.push_back(sweep_out[k]);
        // A finished job, or a sweep over an empty list, clears the list.
        if (finished)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
                job_done[i] = 1'b0;
            job_len      = 0;
            job_done_cnt = 0;
            sweeps_run   = 0;
        end
    endtask

    // Driver: holds a request until it is taken, then either idles or
    // presents the next one from the pending queue.
    always @(negedge clk)
    begin : request_driver
        cmd_t req_out;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || req_taken)
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_out = pending_reqs.pop_front();
                s_axis_tdata  <= {{TPAD_W{1'b0}}, req_out.target, req_out.channel};
                s_axis_tuser  <= req_out.op;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // The update side stalls at random according to the current phase.
    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: feeds each taken request to the predictor and compares each
    // taken update with the oldest expected one.
    always @(posedge clk)
    begin : update_monitor
        cmd_t seen;
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                req_taken    = 1'b1;
                seen.op      = op_t'(s_axis_tuser);
                seen.channel = s_axis_tdata[CH_W-1:0];
                seen.target  = s_axis_tdata[CH_W+LVL_W-1:CH_W];
                fade_predict(seen);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.channel  = m_axis_tdata[CH_W-1:0];
                got.level    = m_axis_tdata[CH_W+LVL_W-1:CH_W];
                got.last     = m_axis_tlast;
                got.finished = m_axis_tuser;
                if (expected_updates.size() == 0)
                begin
                    $error("unexpected update: channel %0d level %0d", got.channel, got.level);
                    mismatches++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (got.channel !== want.channel)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.channel, got.channel);
                        mismatches++;
                    end
                    if (got.level !== want.level)
                    begin
                        $error("out_level: expected %0d, got %0d", want.level, got.level);
                        mismatches++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_of_sweep: expected %0b, got %0b", want.last, got.last);
                        mismatches++;
                    end
                    if (got.finished !== want.finished)
                    begin
                        $error("job_finished: expected %0b, got %0b",
                               want.finished, got.finished);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic push_enrol(input logic [CH_W-1:0] ch, input logic [LVL_W-1:0] tgt);
        cmd_t req;
        req.op      = OP_ENROL;
        req.channel = ch;
        req.target  = tgt;
        pending_reqs.push_back(req);
    endtask

    // A sweep carries random channel and target bits, which the engine ignores.
    task automatic push_sweep();
        cmd_t req;
        req.op      = OP_SWEEP;
        req.channel = CH_W'($urandom_range(31));
        req.target  = LVL_W'($urandom_range(4095));
        pending_reqs.push_back(req);
    endtask

    // Waits until every request has been taken, every expected update has
    // arrived and the engine has had time to finish trailing enrols.
    task automatic wait_quiet();
        int settle;
        settle = 0;
        while (settle < SETTLE_CYCLES)
        begin
            @(posedge clk);
            if (pending_reqs.size() == 0 && !s_axis_tvalid && expected_updates.size() == 0)
                settle++;
            else
                settle = 0;
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_STEP_SIZE)
            step_cfg = val[STEP_W-1:0];
        else
            limit_cfg = val[LIMIT_W-1:0];
    endtask

    // Writes both registers. The step register is 8 bits wide, so the upper
    // byte of the write data is sometimes filled with noise that must be
    // dropped.
    task automatic set_fade_cfg(input logic [STEP_W-1:0] step, input logic [LIMIT_W-1:0] limit);
        logic [CFG_DATA_W-1:0] step_word;
        step_word = {8'h00, step};
        if ($urandom_range(1) == 1)
            step_word[CFG_DATA_W-1:STEP_W] = (CFG_DATA_W-STEP_W)'($urandom_range(255));
        write_reg(REG_STEP_SIZE, step_word);
        write_reg(REG_SWEEP_LIMIT, limit);
    endtask

    // Mostly picks targets a few steps from the channel's present level so
    // that jobs finish by reaching their targets; the rest are extremes or
    // uniform, which usually end through the sweep limit.
    function automatic logic [LVL_W-1:0] pick_target(input logic [CH_W-1:0] ch);
        int               r;
        int               v;
        logic [LVL_W-1:0] t;
        r = $urandom_range(99);
        if (r < 10)
            t = ($urandom_range(1) == 1) ? '1 : '0;
        else if (r < 35)
            t = LVL_W'($urandom_range(4095));
        else
        begin
            v = int'(chan_level[ch]) + (int'($urandom_range(6)) - 3) * int'(step_cfg)
                + int'($urandom_range(2)) - 1;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            t = v[LVL_W-1:0];
        end
        return t;
    endfunction

    initial
    begin : stimulus
        int       issued;
        int       n_enrol;
        int       n_sweep;
        cmd_t     noise;
        logic [CH_W-1:0] ch;

        for (int i = 0; i < NUM_CHANNELS; i++)
            chan_level[i] = '0;
        for (int i = 0; i < NUM_ENTRIES; i++)
            job_done[i] = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling on either side.
        // Largest step with a short limit: a sweep over the empty list, an
        // entry already on target, the level extremes, the same channel
        // enrolled twice, and a gap exactly one step wide, which lands on
        // target and is reported done one sweep later. The third sweep
        // passes the limit and aborts the job.
        set_fade_cfg(8'd255, 16'd2);
        push_sweep();
        push_enrol(5'd0, 12'd0);
        push_enrol(5'd31, 12'd4095);
        push_enrol(5'd31, 12'd10);
        push_enrol(5'd5, 12'd255);
        repeat (3) push_sweep();
        wait_quiet();

        // Step of zero: the off-target entry never moves and the job ends
        // through the limit.
        set_fade_cfg(8'd0, 16'd1);
        push_enrol(5'd1, 12'd7);
        push_enrol(5'd2, 12'd0);
        repeat (2) push_sweep();
        wait_quiet();

        // Smallest step with a zero limit: one sweep always ends the job.
        set_fade_cfg(8'd1, 16'd0);
        push_enrol(5'd5, 12'd256);
        push_sweep();
        wait_quiet();

        // Random part: eight phases that cycle through the idling patterns
        // and a range of register settings. Each phase ends with the sender
        // holding off until every expected update has arrived.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (ph)
                0: set_fade_cfg(8'd1, 16'hFFFF);
                1: set_fade_cfg(8'd255, 16'd0);
                2: set_fade_cfg(STEP_W'($urandom_range(255, 1)), LIMIT_W'($urandom_range(15)));
                3: set_fade_cfg(STEP_RESET, LIMIT_RESET);
                4: set_fade_cfg(STEP_W'($urandom_range(255, 1)), 16'hFFFF);
                5: set_fade_cfg(8'd255, 16'hFFFF);
                6: set_fade_cfg(8'd1, LIMIT_W'($urandom_range(15)));
                default: set_fade_cfg(STEP_W'($urandom_range(255, 1)),
                                      LIMIT_W'($urandom_range(65535)));
            endcase
            issued = 0;
            while (issued < 16)
            begin
                // Keep the driver fed, but let the predictor catch up so that
                // targets can be picked near the present channel levels.
                while (pending_reqs.size() > 1)
                    @(posedge clk);
                if ($urandom_range(99) < 12)
                begin
                    noise.op      = op_t'($urandom_range(1));
                    noise.channel = CH_W'($urandom_range(31));
                    noise.target  = LVL_W'($urandom_range(4095));
                    pending_reqs.push_back(noise);
                    issued++;
                end
                else
                begin
                    // Now and then enough enrols to fill the list and
                    // overflow it.
                    n_enrol = ($urandom_range(11) == 0) ? $urandom_range(34, 28)
                                                        : $urandom_range(5, 1);
                    n_sweep = $urandom_range(6, 1);
                    for (int e = 0; e < n_enrol; e++)
                    begin
                        ch = CH_W'($urandom_range(31));
                        push_enrol(ch, pick_target(ch));
                    end
                    repeat (n_sweep) push_sweep();
                    issued += n_enrol + n_sweep;
                end
            end
            wait_quiet();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
